/* sv/pts_pkg.sv */
// Package for the priority thread scheduler: kinds, status codes, state enum.
// No dependencies.
`default_nettype none
package pts_pkg;
    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_SCHEDULE  = 3'd1,
        KIND_ADD       = 3'd2,
        KIND_KILL_ID   = 3'd3,
        KIND_KILL_CUR  = 3'd4,
        KIND_SLEEP     = 3'd5,
        KIND_BLOCK     = 3'd6,
        KIND_ADD_EVENT = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TABLE_FULL = 3'd1,
        ST_LAST       = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_NO_READY   = 3'd4,
        ST_EVENT_FULL = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EV_CHECK,
        S_EV_EMIT,
        S_WAKE,
        S_FIND,
        S_SCH_FIX,
        S_SCH_FALL,
        S_SCH_WALK,
        S_ADD_LINK,
        S_KILL,
        S_OUT
    } state_t;

    localparam logic [7:0] PRIO_NONE = 8'd255;
endpackage
`default_nettype wire

/* sv/priority_thread_scheduler_unit.sv */
// Top level of the priority thread scheduler: thread ring, event table and
// a sequencer that visits one slot per cycle. A schedule is a dead-slot
// fix-up plus a ring walk. One item at a time; s_tready is high only in the
// idle state. aresetn (synchronous, active low) clears time, counters, marks
// and control.
`default_nettype none
module priority_thread_scheduler_unit
    import pts_pkg::*;
#(
    parameter int THREAD_SLOTS = 8,
    parameter int EVENT_SLOTS  = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // priority_req[7:0], thread_id[23:8], block_value[24],
    // duration[56:25], period[88:57], first_time[120:89], zero[127:121]
    input  wire logic [127:0] s_tdata,
    // kind[2:0]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[2:0], thread_slot[5:3], current_id[21:6], event_index[23:22],
    // switch_request[24], released_lock[25], zero[31:26]
    output logic [31:0]       m_tdata,
    // event_fired[0]
    output logic              m_tuser,
    output logic              m_tlast
);
    localparam int TW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int EW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int CW = $clog2(THREAD_SLOTS + 1);
    localparam int EC = $clog2(EVENT_SLOTS + 1);
    localparam int SC = $clog2(THREAD_SLOTS + 2);

    state_t state_reg, state_next;

    logic [31:0]           time_reg;
    logic [TW-1:0]         cur_reg;
    logic [CW-1:0]         live_reg;
    logic [THREAD_SLOTS-1:0] alive_reg, asleep_reg, blocked_reg;
    logic [7:0]            prio_reg  [THREAD_SLOTS];
    logic [15:0]           ident_reg [THREAD_SLOTS];
    logic [31:0]           wake_reg  [THREAD_SLOTS];
    logic [TW-1:0]         nxt_reg   [THREAD_SLOTS];
    logic [TW-1:0]         prv_reg   [THREAD_SLOTS];
    logic [EC-1:0]         ecnt_reg;
    logic [31:0]           eper_reg  [EVENT_SLOTS];
    logic [31:0]           edue_reg  [EVENT_SLOTS];

    logic [2:0]  kind_reg;
    logic [7:0]  preq_reg;
    logic [15:0] id_reg;
    logic        bval_reg;
    logic [31:0] dur_reg, per_reg, first_reg;

    logic [SC-1:0] idx_reg;
    logic [EC-1:0] ej_reg;
    logic [TW-1:0] p_reg, pick_reg;
    logic          pick_ok_reg;
    logic [7:0]    minp_reg;
    logic [TW-1:0] fslot_reg;

    logic [2:0]    o_status_reg;
    logic [TW-1:0] o_slot_reg;
    logic          o_fired_reg, o_sw_reg, o_rel_reg, o_last_reg;
    logic [1:0]    o_eidx_reg;

    logic [TW-1:0] cur_ok;
    assign cur_ok = (32'(cur_reg) < THREAD_SLOTS) ? cur_reg : '0;

    logic [TW-1:0] first_alive;
    logic          any_alive;
    logic [TW-1:0] first_dead;
    always_comb begin
        first_alive = '0;
        first_dead  = '0;
        any_alive   = |alive_reg;
        for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
            if (alive_reg[i]) first_alive = TW'(i);
            if (!alive_reg[i]) first_dead = TW'(i);
        end
    end

    logic          ready_p;
    logic [TW-1:0] idx_t;
    logic [EW-1:0] ev_i;
    logic [EC-1:0] ev_n;
    assign ready_p = alive_reg[p_reg] && !blocked_reg[p_reg] && !asleep_reg[p_reg];
    assign idx_t   = idx_reg[TW-1:0];
    assign ev_n    = ecnt_reg;
    assign ev_i    = (ej_reg < ev_n) ? ej_reg[EW-1:0] : '0;

    logic [31:0] time_inc;
    assign time_inc = time_reg + 32'd1;

    logic [31:0] m_data_full;
    always_comb begin
        m_data_full        = '0;
        m_data_full[2:0]   = o_status_reg;
        m_data_full[5:3]   = 3'(o_slot_reg);
        m_data_full[21:6]  = ident_reg[cur_ok];
        m_data_full[23:22] = o_eidx_reg;
        m_data_full[24]    = o_sw_reg;
        m_data_full[25]    = o_rel_reg;
    end
    assign m_tdata  = m_data_full;
    assign m_tuser  = o_fired_reg;
    assign m_tlast  = o_last_reg;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT) || (state_reg == S_EV_EMIT);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (s_tvalid) state_next = S_DECODE;
            S_DECODE: begin
                unique case (kind_t'(kind_reg))
                    KIND_TICK:     state_next = S_EV_CHECK;
                    KIND_SCHEDULE: state_next = any_alive ? S_SCH_FIX : S_OUT;
                    KIND_ADD:      state_next = (32'(live_reg) >= THREAD_SLOTS)
                                                ? S_OUT : S_ADD_LINK;
                    KIND_KILL_ID:  state_next = (live_reg == CW'(1)) ? S_OUT : S_FIND;
                    KIND_BLOCK:    state_next = S_FIND;
                    KIND_KILL_CUR: state_next = (alive_reg[cur_ok] && live_reg > CW'(1))
                                                ? S_KILL : S_OUT;
                    default:       state_next = S_OUT;
                endcase
            end
            S_EV_CHECK: begin
                if (ej_reg > ev_n)
                    state_next = S_WAKE;
                else if (time_reg >= edue_reg[ev_i])
                    state_next = S_EV_EMIT;
            end
            S_EV_EMIT:  if (m_tready) state_next = S_EV_CHECK;
            S_WAKE:     if (32'(idx_reg) == THREAD_SLOTS - 1) state_next = S_OUT;
            S_FIND: begin
                if (alive_reg[idx_t] && ident_reg[idx_t] == id_reg)
                    state_next = (kind_t'(kind_reg) == KIND_BLOCK) ? S_OUT : S_KILL;
                else if (32'(idx_reg) == THREAD_SLOTS - 1)
                    state_next = S_OUT;
            end
            S_KILL:     state_next = S_OUT;
            S_ADD_LINK: state_next = S_OUT;
            S_SCH_FIX: begin
                if (alive_reg[p_reg] || 32'(idx_reg) == THREAD_SLOTS)
                    state_next = S_SCH_FALL;
            end
            S_SCH_FALL: state_next = S_SCH_WALK;
            S_SCH_WALK: begin
                if (p_reg == cur_reg || 32'(idx_reg) == THREAD_SLOTS)
                    state_next = S_OUT;
            end
            S_OUT:      if (m_tready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            time_reg    <= '0;
            cur_reg     <= '0;
            live_reg    <= '0;
            ecnt_reg    <= '0;
            alive_reg   <= '0;
            asleep_reg  <= '0;
            blocked_reg <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE: begin
                    kind_reg  <= s_tuser;
                    preq_reg  <= s_tdata[7:0];
                    id_reg    <= s_tdata[23:8];
                    bval_reg  <= s_tdata[24];
                    dur_reg   <= s_tdata[56:25];
                    per_reg   <= s_tdata[88:57];
                    first_reg <= s_tdata[120:89];
                end
                S_DECODE: begin
                    logic [2:0]    st;
                    logic [TW-1:0] sl;
                    logic          sw;
                    st = ST_OK;
                    sl = '0;
                    sw = 1'b0;
                    o_fired_reg  <= 1'b0;
                    o_eidx_reg   <= '0;
                    o_rel_reg    <= 1'b0;
                    o_last_reg   <= 1'b1;
                    idx_reg      <= '0;
                    unique case (kind_t'(kind_reg))
                        KIND_TICK: begin
                            time_reg  <= time_inc;
                            ej_reg    <= EC'(1);
                        end
                        KIND_SCHEDULE: begin
                            if (!any_alive) begin
                                st = ST_NO_READY;
                            end else begin
                                p_reg <= cur_ok;
                            end
                        end
                        KIND_ADD: begin
                            if (32'(live_reg) >= THREAD_SLOTS) begin
                                st = ST_TABLE_FULL;
                            end
                        end
                        KIND_KILL_ID, KIND_BLOCK: begin
                            if (kind_t'(kind_reg) == KIND_KILL_ID
                                && live_reg == CW'(1)) begin
                                st = ST_LAST;
                            end
                        end
                        KIND_KILL_CUR: begin
                            sl = cur_ok;
                            if (!alive_reg[cur_ok]) begin
                                st = ST_NOT_FOUND;
                            end else if (live_reg <= CW'(1)) begin
                                st = ST_LAST;
                            end else begin
                                fslot_reg <= cur_ok;
                                sw = 1'b1;
                            end
                        end
                        KIND_SLEEP: begin
                            asleep_reg[cur_ok] <= 1'b1;
                            wake_reg[cur_ok]   <= time_reg + dur_reg;
                            sl = cur_ok;
                            sw = 1'b1;
                        end
                        default: begin
                            if (32'(ecnt_reg) >= EVENT_SLOTS) begin
                                st = ST_EVENT_FULL;
                            end else begin
                                eper_reg[ecnt_reg[EW-1:0]] <= per_reg;
                                edue_reg[ecnt_reg[EW-1:0]] <= first_reg;
                                ecnt_reg <= ecnt_reg + EC'(1);
                            end
                        end
                    endcase
                    o_status_reg <= st;
                    o_slot_reg   <= sl;
                    o_sw_reg     <= sw;
                end
                S_EV_CHECK: begin
                    o_slot_reg <= cur_ok;
                    if (ej_reg <= ev_n) begin
                        ej_reg <= ej_reg + EC'(1);
                        if (time_reg >= edue_reg[ev_i]) begin
                            edue_reg[ev_i] <= time_reg + eper_reg[ev_i];
                            o_fired_reg    <= 1'b1;
                            o_eidx_reg     <= 2'(ev_i);
                            o_last_reg     <= 1'b0;
                        end
                    end
                end
                S_EV_EMIT: ;
                S_WAKE: begin
                    if (alive_reg[idx_t] && asleep_reg[idx_t]
                        && wake_reg[idx_t] == time_reg)
                        asleep_reg[idx_t] <= 1'b0;
                    idx_reg <= idx_reg + SC'(1);
                    if (32'(idx_reg) == THREAD_SLOTS - 1) begin
                        o_fired_reg <= 1'b0;
                        o_eidx_reg  <= '0;
                        o_sw_reg    <= 1'b1;
                        o_last_reg  <= 1'b1;
                    end
                end
                S_FIND: begin
                    if (alive_reg[idx_t] && ident_reg[idx_t] == id_reg) begin
                        fslot_reg  <= idx_t;
                        o_slot_reg <= idx_t;
                        if (kind_t'(kind_reg) == KIND_BLOCK) begin
                            blocked_reg[idx_t] <= bval_reg;
                        end
                    end else if (32'(idx_reg) == THREAD_SLOTS - 1) begin
                        o_status_reg <= ST_NOT_FOUND;
                    end else begin
                        idx_reg <= idx_reg + SC'(1);
                    end
                end
                S_KILL: begin
                    o_rel_reg              <= blocked_reg[fslot_reg];
                    blocked_reg[fslot_reg] <= 1'b0;
                    alive_reg[fslot_reg]   <= 1'b0;
                    begin
                        logic [TW-1:0] n, p;
                        n = (32'(nxt_reg[fslot_reg]) < THREAD_SLOTS)
                            ? nxt_reg[fslot_reg] : '0;
                        p = (32'(prv_reg[fslot_reg]) < THREAD_SLOTS)
                            ? prv_reg[fslot_reg] : '0;
                        prv_reg[n] <= p;
                        nxt_reg[p] <= n;
                    end
                    if (live_reg != '0) live_reg <= live_reg - CW'(1);
                end
                S_ADD_LINK: begin
                    if (!any_alive) begin
                        nxt_reg[first_dead] <= first_dead;
                        prv_reg[first_dead] <= first_dead;
                    end else begin
                        logic [TW-1:0] pa;
                        pa = (32'(prv_reg[first_alive]) < THREAD_SLOTS)
                            ? prv_reg[first_alive] : '0;
                        nxt_reg[first_dead] <= first_alive;
                        prv_reg[first_dead] <= pa;
                        prv_reg[first_alive] <= first_dead;
                        nxt_reg[pa] <= first_dead;
                    end
                    asleep_reg[first_dead]  <= 1'b0;
                    blocked_reg[first_dead] <= 1'b0;
                    prio_reg[first_dead]    <= preq_reg;
                    ident_reg[first_dead]   <= id_reg;
                    alive_reg[first_dead]   <= 1'b1;
                    live_reg                <= live_reg + CW'(1);
                    o_slot_reg              <= first_dead;
                end
                S_SCH_FIX: begin
                    if (alive_reg[p_reg]) begin
                        p_reg <= p_reg;
                    end else if (32'(idx_reg) == THREAD_SLOTS) begin
                        p_reg <= first_alive;
                    end else begin
                        p_reg   <= (32'(nxt_reg[p_reg]) < THREAD_SLOTS)
                                   ? nxt_reg[p_reg] : '0;
                        idx_reg <= idx_reg + SC'(1);
                    end
                end
                S_SCH_FALL: begin
                    logic [TW-1:0] c;
                    c = (asleep_reg[p_reg] && alive_reg[0]) ? '0 : p_reg;
                    cur_reg     <= c;
                    p_reg       <= (32'(nxt_reg[c]) < THREAD_SLOTS) ? nxt_reg[c] : '0;
                    idx_reg     <= '0;
                    pick_ok_reg <= 1'b0;
                    minp_reg    <= PRIO_NONE;
                end
                S_SCH_WALK: begin
                    if (p_reg == cur_reg || 32'(idx_reg) == THREAD_SLOTS) begin
                        logic cr;
                        cr = alive_reg[cur_reg] && !blocked_reg[cur_reg]
                             && !asleep_reg[cur_reg];
                        if (cr && (!pick_ok_reg || prio_reg[cur_reg] < minp_reg)) begin
                            o_slot_reg <= cur_reg;
                        end else if (pick_ok_reg) begin
                            o_slot_reg <= pick_reg;
                            cur_reg    <= pick_reg;
                        end else begin
                            o_slot_reg   <= cur_reg;
                            o_status_reg <= ST_NO_READY;
                        end
                    end else begin
                        if (ready_p && prio_reg[p_reg] <= minp_reg) begin
                            minp_reg    <= prio_reg[p_reg];
                            pick_reg    <= p_reg;
                            pick_ok_reg <= 1'b1;
                        end
                        p_reg   <= (32'(nxt_reg[p_reg]) < THREAD_SLOTS)
                                   ? nxt_reg[p_reg] : '0;
                        idx_reg <= idx_reg + SC'(1);
                    end
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

/* sv/pts_checker.sv */
// Port-level checker for the priority thread scheduler, bound to the top level.
// Depends on priority_thread_scheduler_unit ports only.
`default_nettype none
module pts_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [31:0]  m_tdata,
    input wire logic         m_tuser,
    input wire logic         m_tlast
);
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("result changed while stalled");
    a_fired_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tlast) else $error("event result marked last");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] != 3'd6 && m_tdata[2:0] != 3'd7)
        else $error("bad status");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("ready after accept");
endmodule

bind priority_thread_scheduler_unit pts_checker u_pts_checker (.*);
`default_nettype wire
